// File: rtl/cwr_pkg.sv
`default_nettype none
package cwr_pkg;

  localparam int SCREEN_ROWS = 25;
  localparam int SCREEN_COLS = 80;
  localparam int TAB_WIDTH   = 4;
  localparam int CELL_COUNT  = SCREEN_ROWS * SCREEN_COLS;

  // Cell address, counter able to hold CELL_COUNT, row and column widths
  localparam int ADDR_W  = $clog2(CELL_COUNT);
  localparam int CNT_W   = $clog2(CELL_COUNT + 1);
  localparam int ROW_W   = (SCREEN_ROWS > 1) ? $clog2(SCREEN_ROWS) : 1;
  localparam int COL_W   = $clog2(SCREEN_COLS + 1);
  localparam int TAB_W   = $clog2(TAB_WIDTH + 1);
  localparam int CELL_W  = 16;
  localparam int COLOR_W = 4;
  localparam int POS_W   = 11;

  // Operations
  localparam logic [1:0] OP_PUT     = 2'd0;
  localparam logic [1:0] OP_READ    = 2'd1;
  localparam logic [1:0] OP_CLEAR   = 2'd2;
  localparam logic [1:0] OP_REPAINT = 2'd3;

  // Control bytes
  localparam logic [7:0] CH_BS    = 8'd8;
  localparam logic [7:0] CH_TAB   = 8'd9;
  localparam logic [7:0] CH_NL    = 8'd10;
  localparam logic [7:0] CH_CR    = 8'd13;
  localparam logic [7:0] CH_SPACE = 8'd32;

  // Register indexes
  localparam int CFG_IDX_W = 2;
  localparam logic [CFG_IDX_W-1:0] CFG_FG = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_BG = 2'd1;

  typedef struct packed {
    logic [1:0]  op;
    logic [7:0]  char_code;
    logic [10:0] cell_index;
    logic        is_tab;
  } cwr_item_t;

endpackage
`default_nettype wire

// File: rtl/cwr_ram.sv
`default_nettype none
module cwr_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 2000
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output logic      [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // Write, then registered read
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule
`default_nettype wire

// File: rtl/cwr_front.sv
`default_nettype none
module cwr_front (
  input  wire logic              clk,
  input  wire logic              rst,
  input  wire logic              push,
  input  wire logic [1:0]        op,
  input  wire logic [7:0]        char_code,
  input  wire logic [10:0]       cell_index,
  input  wire logic              hold,
  output logic                   full,
  output logic                   item_valid,
  output cwr_pkg::cwr_item_t     item,
  input  wire logic              item_pop
);
  import cwr_pkg::*;

  cwr_item_t  slot [2];
  logic       wr_ptr;
  logic       rd_ptr;
  logic [1:0] count;
  logic       take;

  assign full       = (count == 2'd2) || hold;
  assign take       = push && !full;
  assign item_valid = (count != 2'd0);
  assign item       = slot[rd_ptr];

  // Classify and hold accepted items
  always_ff @(posedge clk) begin
    if (take) begin
      slot[wr_ptr] <= '{op: op, char_code: char_code, cell_index: cell_index,
                         is_tab: (char_code == CH_TAB)};
    end
  end

  // Advance pointers
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= 1'b0;
      rd_ptr <= 1'b0;
      count  <= 2'd0;
    end else begin
      if (take) begin
        wr_ptr <= !wr_ptr;
      end
      if (item_pop) begin
        rd_ptr <= !rd_ptr;
      end
      count <= count + 2'(take) - 2'(item_pop);
    end
  end

  a_no_pop_empty: assert property (@(posedge clk) disable iff (rst)
    item_pop |-> count != 2'd0) else $error("pop from empty item queue");
  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    count != 2'd3) else $error("item queue count overflow");
  a_hold_count: assert property (@(posedge clk) disable iff (rst)
    (count == 2'd2 && !item_pop) |=> count == 2'd2) else $error("item lost");

endmodule
`default_nettype wire

// File: rtl/cwr_back.sv
`default_nettype none
module cwr_back (
  input  wire logic                         clk,
  input  wire logic                         rst,
  input  wire logic [cwr_pkg::COLOR_W-1:0]  fg,
  input  wire logic [cwr_pkg::COLOR_W-1:0]  bg,
  input  wire logic                         item_valid,
  input  wire cwr_pkg::cwr_item_t           item,
  output logic                              item_pop,
  output logic                              clearing,
  output logic                              empty,
  input  wire logic                         pop,
  output logic [cwr_pkg::POS_W-1:0]         cursor_pos,
  output logic [cwr_pkg::CELL_W-1:0]        cell_data,
  output logic                              scrolled
);
  import cwr_pkg::*;

  localparam logic [3:0] S_IDLE  = 4'd0;
  localparam logic [3:0] S_PUT   = 4'd1;
  localparam logic [3:0] S_FILL  = 4'd2;
  localparam logic [3:0] S_NLEND = 4'd3;
  localparam logic [3:0] S_RMW   = 4'd4;
  localparam logic [3:0] S_NLRET = 4'd5;
  localparam logic [3:0] S_READW = 4'd6;
  localparam logic [3:0] S_FIN   = 4'd7;

  localparam logic [CNT_W-1:0] CELLS    = CNT_W'(CELL_COUNT);
  localparam logic [CNT_W-1:0] COLS_C   = CNT_W'(SCREEN_COLS);
  localparam logic [CNT_W-1:0] LAST_ROW = CNT_W'(CELL_COUNT - SCREEN_COLS);
  localparam logic [COL_W-1:0] COL_END  = COL_W'(SCREEN_COLS);
  localparam logic [ROW_W-1:0] ROW_LAST = ROW_W'(SCREEN_ROWS - 1);

  logic [3:0]        state;
  logic [3:0]        ret_state;
  logic [ROW_W-1:0]  row;
  logic [COL_W-1:0]  col;
  logic [CNT_W-1:0]  row_base;
  logic [CNT_W-1:0]  cnt;
  logic [CNT_W-1:0]  sweep_end;
  logic              byte_done;
  logic              rmw_copy;
  logic [TAB_W-1:0]  tab_cnt;
  logic [7:0]        cur_ch;
  logic              pv;
  logic [CNT_W-1:0]  pw;
  logic [CELL_W-1:0] data_q;
  logic              scr;
  logic              res_full;

  logic              we;
  logic [ADDR_W-1:0] waddr;
  logic [CELL_W-1:0] wdata;
  logic [ADDR_W-1:0] raddr;
  logic [CELL_W-1:0] rdata;
  logic [CNT_W-1:0]  put_addr;
  logic [CNT_W-1:0]  rd_addr;
  logic [CELL_W-1:0] blank;

  cwr_ram #(.WIDTH(CELL_W), .DEPTH(CELL_COUNT)) u_ram (
    .clk   (clk),
    .we    (we),
    .waddr (waddr),
    .wdata (wdata),
    .raddr (raddr),
    .rdata (rdata)
  );

  assign put_addr = row_base + CNT_W'(col);
  assign blank    = {bg, 12'h000};
  assign clearing = (state == S_FILL) && (ret_state == S_IDLE);
  assign item_pop = (state == S_IDLE) && item_valid;
  assign empty    = !res_full;

  // Steer the memory ports
  always_comb begin
    we      = 1'b0;
    waddr   = '0;
    wdata   = '0;
    rd_addr = cnt + (rmw_copy ? COLS_C : '0);
    if (state == S_IDLE) begin
      rd_addr = CNT_W'(item.cell_index);
    end
    raddr = rd_addr[ADDR_W-1:0];
    if (pv) begin
      we    = 1'b1;
      waddr = pw[ADDR_W-1:0];
      wdata = rmw_copy ? rdata : {bg, rdata[11:0]};
    end else begin
      case (state)
        S_FILL: begin
          if (cnt != sweep_end) begin
            we    = 1'b1;
            waddr = cnt[ADDR_W-1:0];
            wdata = (ret_state == S_IDLE) ? '0 : blank;
          end
        end
        S_PUT: begin
          if (col != COL_END && cur_ch != CH_NL && cur_ch != CH_CR) begin
            if (cur_ch == CH_BS) begin
              if (col != '0) begin
                we    = 1'b1;
                waddr = ADDR_W'(put_addr - CNT_W'(1));
                wdata = blank;
              end
            end else begin
              we    = 1'b1;
              waddr = put_addr[ADDR_W-1:0];
              wdata = {bg, fg, cur_ch};
            end
          end
        end
        default: begin
        end
      endcase
    end
  end

  // Sequence the work of one item
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_FILL;
      ret_state <= S_IDLE;
      cnt       <= '0;
      sweep_end <= CELLS;
      row       <= '0;
      col       <= '0;
      row_base  <= '0;
      pv        <= 1'b0;
      res_full  <= 1'b0;
      rmw_copy  <= 1'b0;
    end else begin
      pv <= (state == S_RMW) && (cnt != sweep_end);
      pw <= cnt;
      if (pop && res_full && state != S_FIN) begin
        res_full <= 1'b0;
      end
      case (state)
        S_IDLE: begin
          if (item_valid) begin
            scr    <= 1'b0;
            data_q <= '0;
            case (item.op)
              OP_PUT: begin
                cur_ch  <= item.is_tab ? CH_SPACE : item.char_code;
                tab_cnt <= item.is_tab ? TAB_W'(TAB_WIDTH - 1) : '0;
                state   <= S_PUT;
              end
              OP_READ: begin
                state <= (CNT_W'(item.cell_index) < CELLS) ? S_READW : S_FIN;
              end
              OP_CLEAR: begin
                row       <= '0;
                col       <= '0;
                row_base  <= '0;
                cnt       <= '0;
                sweep_end <= CELLS;
                ret_state <= S_FIN;
                state     <= S_FILL;
              end
              default: begin
                cnt       <= '0;
                sweep_end <= CELLS;
                rmw_copy  <= 1'b0;
                state     <= S_RMW;
              end
            endcase
          end
        end
        S_READW: begin
          data_q <= rdata;
          state  <= S_FIN;
        end
        S_PUT: begin
          if (col == COL_END || cur_ch == CH_NL) begin
            byte_done <= (col != COL_END);
            cnt       <= put_addr;
            sweep_end <= row_base + COLS_C;
            ret_state <= S_NLEND;
            state     <= S_FILL;
          end else begin
            case (cur_ch)
              CH_CR:   col <= '0;
              CH_BS:   col <= (col != '0) ? col - COL_W'(1) : col;
              default: col <= col + COL_W'(1);
            endcase
            if (tab_cnt != '0) begin
              tab_cnt <= tab_cnt - TAB_W'(1);
            end else begin
              state <= S_FIN;
            end
          end
        end
        S_FILL: begin
          if (cnt == sweep_end) begin
            state <= ret_state;
          end else begin
            cnt <= cnt + CNT_W'(1);
          end
        end
        S_NLEND: begin
          col <= '0;
          if (row == ROW_LAST) begin
            scr       <= 1'b1;
            cnt       <= '0;
            sweep_end <= LAST_ROW;
            rmw_copy  <= 1'b1;
            state     <= S_RMW;
          end else begin
            row      <= row + ROW_W'(1);
            row_base <= row_base + COLS_C;
            state    <= byte_done ? S_FIN : S_PUT;
          end
        end
        S_RMW: begin
          if (cnt != sweep_end) begin
            cnt <= cnt + CNT_W'(1);
          end else if (rmw_copy) begin
            cnt       <= LAST_ROW;
            sweep_end <= CELLS;
            ret_state <= S_NLRET;
            state     <= S_FILL;
          end else begin
            state <= S_FIN;
          end
        end
        S_NLRET: begin
          state <= byte_done ? S_FIN : S_PUT;
        end
        S_FIN: begin
          if (!res_full || pop) begin
            res_full   <= 1'b1;
            cursor_pos <= POS_W'(put_addr);
            cell_data  <= data_q;
            scrolled   <= scr;
            state      <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  a_pipe_src: assert property (@(posedge clk) disable iff (rst)
    pv |-> $past(state) == S_RMW) else $error("stray pipelined write");
  a_col_range: assert property (@(posedge clk) disable iff (rst)
    col <= COL_END) else $error("column out of range");
  a_row_range: assert property (@(posedge clk) disable iff (rst)
    row <= ROW_LAST) else $error("row out of range");
  a_result_held: assert property (@(posedge clk) disable iff (rst)
    (state == S_FIN && res_full && !pop) |=> state == S_FIN)
    else $error("result overwritten");
  a_no_take_clear: assert property (@(posedge clk) disable iff (rst)
    clearing |-> !item_pop) else $error("item taken during clear pass");

endmodule
`default_nettype wire

// File: rtl/text_console_writer.sv
// Channel  | Handshake              | Payload
// input    | push / full            | op, char_code, cell_index
// result   | empty / pop            | cursor_pos, cell_data, scrolled
// config   | cfg_valid / cfg_ready  | cfg_index, cfg_data
//
// A plain byte, carriage return, backspace, tab or cell read is handled in the
// back end one cell write or read at a time. A newline blanks the rest of the
// row and, on the bottom row, scrolls by copying every row up one and blanking
// the last, all paced by the single write port of the screen memory. Clear and
// repaint sweep every cell. After reset a clearing pass over every cell runs
// with full held high. A two-item queue in front and a result register behind
// let either side stall without stopping the other.
`default_nettype none
module text_console_writer (
  input  wire logic                          clk,
  input  wire logic                          rst,
  input  wire logic                          push,
  output logic                               full,
  input  wire logic [1:0]                    op,
  input  wire logic [7:0]                    char_code,
  input  wire logic [10:0]                   cell_index,
  output logic                               empty,
  input  wire logic                          pop,
  output logic [10:0]                        cursor_pos,
  output logic [15:0]                        cell_data,
  output logic                               scrolled,
  input  wire logic                          cfg_valid,
  output logic                               cfg_ready,
  input  wire logic [cwr_pkg::CFG_IDX_W-1:0] cfg_index,
  input  wire logic [3:0]                    cfg_data
);
  import cwr_pkg::*;

  logic [COLOR_W-1:0] fg;
  logic [COLOR_W-1:0] bg;
  logic               item_valid;
  logic               item_pop;
  logic               clearing;
  cwr_item_t          item;

  assign cfg_ready = 1'b1;

  // Hold colour registers
  always_ff @(posedge clk) begin
    if (rst) begin
      fg <= 4'd12;
      bg <= 4'd0;
    end else if (cfg_valid) begin
      if (cfg_index == CFG_FG) begin
        fg <= cfg_data;
      end else if (cfg_index == CFG_BG) begin
        bg <= cfg_data;
      end
    end
  end

  cwr_front u_front (
    .clk        (clk),
    .rst        (rst),
    .push       (push),
    .op         (op),
    .char_code  (char_code),
    .cell_index (cell_index),
    .hold       (clearing),
    .full       (full),
    .item_valid (item_valid),
    .item       (item),
    .item_pop   (item_pop)
  );

  cwr_back u_back (
    .clk        (clk),
    .rst        (rst),
    .fg         (fg),
    .bg         (bg),
    .item_valid (item_valid),
    .item       (item),
    .item_pop   (item_pop),
    .clearing   (clearing),
    .empty      (empty),
    .pop        (pop),
    .cursor_pos (cursor_pos),
    .cell_data  (cell_data),
    .scrolled   (scrolled)
  );

endmodule
`default_nettype wire

// File: test/text_console_writer_test.sv
`timescale 1ns / 100ps
`default_nettype none
module text_console_writer_test;
  import cwr_pkg::*;

  localparam int WATCHDOG_LIMIT = 200000;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic push = 1'b0;
  logic full;
  logic [1:0] op = OP_PUT;
  logic [7:0] char_code = '0;
  logic [10:0] cell_index = '0;
  logic empty;
  logic pop = 1'b0;
  logic [10:0] cursor_pos;
  logic [15:0] cell_data;
  logic scrolled;
  logic cfg_valid = 1'b0;
  logic cfg_ready;
  logic [CFG_IDX_W-1:0] cfg_index = CFG_FG;
  logic [3:0] cfg_data = '0;

  typedef struct packed {
    logic [10:0] pos;
    logic [15:0] data;
    logic        scr;
  } console_result_t;

  // Shadow screen and cursor
  logic [15:0] shadow_cells [CELL_COUNT];
  int unsigned shadow_row;
  int unsigned shadow_col;
  logic [3:0] shadow_fg;
  logic [3:0] shadow_bg;
  logic shadow_scrolled;

  console_result_t pending_results[$];
  int error_count = 0;
  int idle_cycles = 0;
  bit pop_quiet = 1'b0;

  text_console_writer dut (.*);

  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  task automatic report_mismatch(input string what, input int got, input int want);
    $display("mismatch %s: got %0h expected %0h", what, got, want);
    error_count++;
  endtask

  function automatic logic [15:0] blank_word();
    return {shadow_bg, 12'h000};
  endfunction

  function automatic void shadow_newline();
    for (int unsigned c = shadow_col; c < SCREEN_COLS; c++)
      shadow_cells[shadow_row * SCREEN_COLS + c] = blank_word();
    shadow_col = 0;
    if (shadow_row + 1 >= SCREEN_ROWS) begin
      for (int i = 0; i < CELL_COUNT - SCREEN_COLS; i++)
        shadow_cells[i] = shadow_cells[i + SCREEN_COLS];
      for (int i = CELL_COUNT - SCREEN_COLS; i < CELL_COUNT; i++)
        shadow_cells[i] = blank_word();
      shadow_scrolled = 1'b1;
    end else begin
      shadow_row++;
    end
  endfunction

  function automatic void shadow_put(input logic [7:0] ch);
    if (shadow_col >= SCREEN_COLS) shadow_newline();
    case (ch)
      CH_NL: shadow_newline();
      CH_CR: shadow_col = 0;
      CH_TAB: for (int k = 0; k < TAB_WIDTH; k++) shadow_put(CH_SPACE);
      CH_BS: begin
        if (shadow_col > 0) begin
          shadow_col--;
          shadow_cells[shadow_row * SCREEN_COLS + shadow_col] = blank_word();
        end
      end
      default: begin
        shadow_cells[shadow_row * SCREEN_COLS + shadow_col] = {shadow_bg, shadow_fg, ch};
        shadow_col++;
      end
    endcase
  endfunction

  // Work out the result that one item causes
  function automatic console_result_t predict_console(input logic [1:0] o,
      input logic [7:0] ch, input logic [10:0] idx);
    console_result_t r;
    r.data = '0;
    shadow_scrolled = 1'b0;
    case (o)
      OP_PUT: shadow_put(ch);
      OP_READ: if (idx < CELL_COUNT) r.data = shadow_cells[idx];
      OP_CLEAR: begin
        for (int i = 0; i < CELL_COUNT; i++) shadow_cells[i] = blank_word();
        shadow_row = 0;
        shadow_col = 0;
      end
      default:
        for (int i = 0; i < CELL_COUNT; i++)
          shadow_cells[i] = {shadow_bg, shadow_cells[i][11:0]};
    endcase
    r.pos = 11'(shadow_row * SCREEN_COLS + shadow_col);
    r.scr = shadow_scrolled;
    return r;
  endfunction

  // Push stays high between back-to-back items and drops only for a gap
  task automatic send_item(input logic [1:0] o, input logic [7:0] ch,
      input logic [10:0] idx);
    int gap;
    gap = $urandom_range(0, 19);
    if ($urandom_range(0, 3) == 0) gap = 0;
    if (gap != 0) begin
      push <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    push <= 1'b1;
    op <= o;
    char_code <= ch;
    cell_index <= idx;
    @(posedge clk);
    while (full) @(posedge clk);
    pending_results.push_back(predict_console(o, ch, idx));
  endtask

  // Write a colour register once everything has drained
  task automatic write_colour(input logic [CFG_IDX_W-1:0] idx, input logic [3:0] val);
    push <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk);
    repeat (10) @(posedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    cfg_valid <= 1'b0;
    if (idx == CFG_FG) shadow_fg = val;
    else if (idx == CFG_BG) shadow_bg = val;
  endtask

  // Check each popped result against the oldest expectation
  always @(posedge clk) begin
    if (!rst && pop && !empty) begin
      if (pending_results.size() == 0) begin
        report_mismatch("unexpected result", cursor_pos, 0);
      end else begin
        console_result_t e;
        e = pending_results.pop_front();
        if (cursor_pos !== e.pos) report_mismatch("cursor_pos", cursor_pos, e.pos);
        if (cell_data !== e.data) report_mismatch("cell_data", cell_data, e.data);
        if (scrolled !== e.scr) report_mismatch("scrolled", scrolled, e.scr);
      end
    end
  end

  // Stall the result side at random
  initial begin
    int stall;
    forever begin
      pop <= 1'b1;
      @(posedge clk);
      while (empty) @(posedge clk);
      stall = pop_quiet ? 0 : $urandom_range(0, 19);
      if ($urandom_range(0, 3) == 0) stall = 0;
      if (stall != 0) begin
        pop <= 1'b0;
        repeat (stall) @(posedge clk);
      end
    end
  end

  // End the run when nothing moves for too long
  always @(posedge clk) begin
    if ((push && !full) || (pop && !empty) || (cfg_valid && cfg_ready) || rst)
      idle_cycles <= 0;
    else
      idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= WATCHDOG_LIMIT) begin
      $display("[text_console_writer] ERROR");
      $finish;
    end
  end

  task automatic test_directed();
    send_item(OP_PUT, 8'h41, '0);
    send_item(OP_PUT, 8'hFF, '0);
    send_item(OP_PUT, 8'h00, '0);
    send_item(OP_READ, '0, 11'd0);
    send_item(OP_READ, '0, 11'd1);
    send_item(OP_PUT, CH_BS, '0);
    send_item(OP_PUT, CH_CR, '0);
    send_item(OP_PUT, CH_BS, '0);   // at column zero: no effect
    send_item(OP_PUT, CH_TAB, '0);
    send_item(OP_PUT, CH_NL, '0);
    send_item(OP_READ, '0, 11'd1999);
    send_item(OP_READ, '0, 11'd2000);
    send_item(OP_READ, '0, 11'h7FF);
    send_item(OP_REPAINT, '0, '0);
    send_item(OP_CLEAR, '0, '0);
    send_item(OP_READ, '0, 11'd5);
  endtask

  // Fill rows to the end so pending wrap and bottom-row scroll occur
  task automatic test_wrap_and_scroll();
    for (int i = 0; i < SCREEN_COLS; i++) send_item(OP_PUT, 8'(8'h30 + i % 10), '0);
    send_item(OP_READ, '0, 11'd79);
    send_item(OP_PUT, CH_NL, '0);
    for (int r = 0; r < SCREEN_ROWS; r++) send_item(OP_PUT, CH_NL, '0);
    for (int i = 0; i < SCREEN_COLS; i++) send_item(OP_PUT, 8'h61, '0);
    send_item(OP_PUT, CH_TAB, '0);
    send_item(OP_READ, '0, 11'(CELL_COUNT - SCREEN_COLS));
  endtask

  task automatic test_random(input int count);
    logic [1:0] o;
    logic [7:0] ch;
    for (int n = 0; n < count; n++) begin
      case ($urandom_range(0, 19))
        0: o = OP_CLEAR;
        1: o = OP_REPAINT;
        2, 3, 4, 5: o = OP_READ;
        default: o = OP_PUT;
      endcase
      case ($urandom_range(0, 9))
        0: ch = CH_NL;
        1: ch = CH_BS;
        2: ch = CH_TAB;
        3: ch = CH_CR;
        default: ch = 8'($urandom_range(0, 255));
      endcase
      send_item(o, ch, ($urandom_range(0, 7) == 0) ? 11'($urandom_range(0, 2047))
                                                  : 11'($urandom_range(0, CELL_COUNT - 1)));
    end
  endtask

  initial begin
    shadow_row = 0;
    shadow_col = 0;
    shadow_fg = 4'd12;
    shadow_bg = 4'd0;
    for (int i = 0; i < CELL_COUNT; i++) shadow_cells[i] = '0;
    repeat (2) @(posedge clk);
    rst <= 1'b0;
    test_directed();
    test_wrap_and_scroll();
    write_colour(CFG_FG, 4'hF);
    write_colour(CFG_BG, 4'hF);
    test_directed();
    test_random(100);
    write_colour(CFG_FG, 4'h0);
    write_colour(CFG_BG, 4'h0);
    test_random(100);
    write_colour(CFG_FG, 4'(($urandom_range(0, 15))));
    write_colour(CFG_BG, 4'h5);
    pop_quiet = 1'b1;
    test_random(100);
    push <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk);
    repeat (4200) @(posedge clk);
    if (error_count == 0 && pending_results.size() == 0) begin
      $display("[text_console_writer] OK");
    end else begin
      $display("[text_console_writer] ERROR");
    end
    $finish;
  end
endmodule
`default_nettype wire
